### design/colormap_lookup_interpolate_defines.svh
// Assertion macros for the checker file.
`ifndef COLORMAP_LOOKUP_INTERPOLATE_DEFINES_SVH
`define COLORMAP_LOOKUP_INTERPOLATE_DEFINES_SVH

// Checked at every rising edge, reset included.
`define CLUT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while the block is out of reset.
`define CLUT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### design/clut_pkg.sv
`default_nettype none
package clut_pkg;

  // Palette and sample geometry.
  localparam int MAX_COLORS = 64;
  localparam int IDX_W      = $clog2(MAX_COLORS);
  localparam int FRAC_BITS  = 16;
  localparam int SAMPLE_W   = 18;
  localparam int CNT_W      = 7;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int PROD_W     = SAMPLE_W - 1 + CNT_W;
  localparam int SEL_W      = PROD_W - FRAC_BITS;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  // Commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  // Mapping modes.
  localparam logic MODE_LINEAR  = 1'b0;
  localparam logic MODE_NEAREST = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic                 is_map;
    logic [IDX_W-1:0]     idx_a;
    logic [IDX_W-1:0]     idx_b;
    logic [FRAC_BITS-1:0] frac;
    logic [RGB_W-1:0]     rgb;
  } clut_item_t;

endpackage
`default_nettype wire

### design/clut_if.sv
`default_nettype none
// Input channel: palette writes and map requests.
interface clut_in_if import clut_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [IDX_W-1:0]           entry_index;
  logic [CH_W-1:0]            entry_red;
  logic [CH_W-1:0]            entry_green;
  logic [CH_W-1:0]            entry_blue;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, command, entry_index, entry_red, entry_green,
                  entry_blue, sample_value, input ready);
  modport sink (input valid, command, entry_index, entry_red, entry_green,
                entry_blue, sample_value, output ready);
endinterface

// Result channel: mapped colors.
interface clut_out_if import clut_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

### design/clut_front.sv
`default_nettype none
module clut_front import clut_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  clut_in_if.sink               in_ch,
  input  wire logic             map_mode,
  input  wire logic [CNT_W-1:0] color_count,
  output clut_item_t            item,
  output logic                  item_valid,
  input  wire logic             item_ready
);

  logic [CNT_W-1:0]     n_used;
  logic [CNT_W-1:0]     n_top;
  logic                 neg;
  logic                 big;
  logic [FRAC_BITS-1:0] u_clamp;
  logic [SAMPLE_W-2:0]  mul_a;
  logic [CNT_W-1:0]     mul_b;
  logic [PROD_W-1:0]    prod;
  logic [SEL_W-1:0]     sel;
  logic [IDX_W-1:0]     idx;
  logic                 accept;
  clut_item_t           item_nxt;
  clut_item_t           item_r;
  logic                 valid_r;

  // Entry count in use, held to 2..MAX_COLORS.
  always_comb begin
    if (color_count < CNT_W'(2)) begin
      n_used = CNT_W'(2);
    end else if (color_count > CNT_W'(MAX_COLORS)) begin
      n_used = CNT_W'(MAX_COLORS);
    end else begin
      n_used = color_count;
    end
    n_top = n_used - CNT_W'(1);
  end

  // One shared multiplier: clamped sample times (count-1) in linear mode,
  // raw sample times count in nearest mode. Negative samples give zero.
  always_comb begin
    neg     = in_ch.sample_value[SAMPLE_W-1];
    big     = |in_ch.sample_value[SAMPLE_W-2:FRAC_BITS];
    u_clamp = big ? {FRAC_BITS{1'b1}} : in_ch.sample_value[FRAC_BITS-1:0];
    if (neg) begin
      mul_a = '0;
    end else if (map_mode == MODE_NEAREST) begin
      mul_a = in_ch.sample_value[SAMPLE_W-2:0];
    end else begin
      mul_a = (SAMPLE_W-1)'(u_clamp);
    end
    mul_b = (map_mode == MODE_NEAREST) ? n_used : n_top;
    prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    sel   = prod[PROD_W-1:FRAC_BITS];
    // Only nearest mode can run past the last entry.
    if (sel > SEL_W'(n_top)) begin
      idx = IDX_W'(n_top);
    end else begin
      idx = IDX_W'(sel);
    end
  end

  // Classify the item for the back end.
  always_comb begin
    item_nxt.rgb = {in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue};
    if (in_ch.command == CMD_WRITE) begin
      item_nxt.is_map = 1'b0;
      item_nxt.idx_a  = in_ch.entry_index;
      item_nxt.idx_b  = in_ch.entry_index;
      item_nxt.frac   = '0;
    end else if (map_mode == MODE_NEAREST) begin
      item_nxt.is_map = 1'b1;
      item_nxt.idx_a  = idx;
      item_nxt.idx_b  = idx;
      item_nxt.frac   = '0;
    end else begin
      item_nxt.is_map = 1'b1;
      item_nxt.idx_a  = idx;
      item_nxt.idx_b  = idx + IDX_W'(1);
      item_nxt.frac   = prod[FRAC_BITS-1:0];
    end
  end

  assign in_ch.ready = !valid_r || item_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Front register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule
`default_nettype wire

### design/clut_queue.sv
`default_nettype none
module clut_queue import clut_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire clut_item_t push_item,
  input  wire logic       push_valid,
  output logic            push_ready,
  output clut_item_t      pop_item,
  output logic            pop_valid,
  input  wire logic       pop_ready
);

  clut_item_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  // Occupancy tracking.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### design/clut_back.sv
`default_nettype none
module clut_back import clut_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire clut_item_t item,
  input  wire logic       item_valid,
  output logic            item_ready,
  clut_out_if.source      out_ch
);

  logic [RGB_W-1:0]     palette [MAX_COLORS];
  logic [RGB_W-1:0]     rd_a_r;
  logic [RGB_W-1:0]     rd_b_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic                 v1_r;
  logic                 v2_r;
  logic                 s2_ready;
  logic                 pop;
  logic                 pal_we;
  logic                 pal_re;
  logic [RGB_W-1:0]     blend_rgb;
  logic [RGB_W-1:0]     rgb_r;

  assign s2_ready   = !v2_r || out_ch.ready;
  assign item_ready = !v1_r || s2_ready;
  assign pop        = item_valid && item_ready;
  assign pal_we     = pop && !item.is_map;
  assign pal_re     = pop && item.is_map;

  // Palette memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette[item.idx_a] <= item.rgb;
    end
    if (pal_re) begin
      rd_a_r <= palette[item.idx_a];
      rd_b_r <= palette[item.idx_b];
      frac_r <= item.frac;
    end
  end

  // Read stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (item_ready) begin
      v1_r <= pal_re;
    end
  end

  // Per-channel blend: a + floor((b - a) * f / 2^FRAC_BITS), which equals the
  // truncated weighted sum. Nearest items carry a zero fraction.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [CH_W:0]             diff;
      logic signed [CH_W+FRAC_BITS+1:0] wprod;
      logic signed [CH_W+1:0]           step;
      diff  = $signed({1'b0, rd_b_r[ch*CH_W +: CH_W]}) -
              $signed({1'b0, rd_a_r[ch*CH_W +: CH_W]});
      wprod = diff * $signed({1'b0, frac_r});
      step  = (CH_W+2)'(wprod >>> FRAC_BITS);
      blend_rgb[ch*CH_W +: CH_W] = rd_a_r[ch*CH_W +: CH_W] + step[CH_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_ready) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && v1_r) begin
      rgb_r <= blend_rgb;
    end
  end

  assign out_ch.valid     = v2_r;
  assign out_ch.out_red   = rgb_r[3*CH_W-1:2*CH_W];
  assign out_ch.out_green = rgb_r[2*CH_W-1:CH_W];
  assign out_ch.out_blue  = rgb_r[CH_W-1:0];

endmodule
`default_nettype wire

### design/colormap_lookup_interpolate.sv
`default_nettype none
// Channel   Direction  Handshake        Payload
// in_ch     input      valid / ready    command, entry fields, sample_value
// out_ch    output     valid / ready    out_red, out_green, out_blue
// cfg_*     input      cfg_we only      cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ch.ready holds; each map result passes
// through the front register, queue, palette read and output register in turn.
// Write items update the palette and give no result.
// Reset is synchronous; the palette holds no reset state and must be written
// before it is read.
// A stalled output fills the pipeline and the two-entry queue, after which
// in_ch.ready drops.
module colormap_lookup_interpolate import clut_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  clut_in_if.sink                    in_ch,
  clut_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic       map_mode_r;
  logic [CNT_W-1:0] color_count_r;
  clut_item_t f_item;
  logic       f_valid;
  logic       f_ready;
  clut_item_t q_item;
  logic       q_valid;
  logic       q_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r    <= MODE_LINEAR;
      color_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_MODE:    map_mode_r    <= cfg_wdata[0];
        CFG_COLOR_COUNT: color_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  clut_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .map_mode    (map_mode_r),
    .color_count (color_count_r),
    .item        (f_item),
    .item_valid  (f_valid),
    .item_ready  (f_ready)
  );

  clut_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  clut_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

### design/clut_checker.sv
`default_nettype none
`include "colormap_lookup_interpolate_defines.svh"
module clut_checker import clut_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [CH_W-1:0] out_red,
  input wire logic [CH_W-1:0] out_green,
  input wire logic [CH_W-1:0] out_blue
);

  // Reset empties the result side.
  `CLUT_ASSERT(a_reset_out, !rst_n |=> !out_valid, "result valid after reset")

  // Reset leaves the block able to take an item at once.
  `CLUT_ASSERT(a_reset_ready, !rst_n |=> in_ready, "input not ready after reset")

  // A stalled result stays offered with the same color.
  `CLUT_ASSERT_RUN(a_hold, out_valid && !out_ready |=> out_valid &&
    $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled result changed")

endmodule

bind colormap_lookup_interpolate clut_checker u_clut_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.out_red),
  .out_green (out_ch.out_green),
  .out_blue  (out_ch.out_blue)
);
`default_nettype wire

### sim/tb_colormap_lookup_interpolate.sv
`timescale 1ns / 1ps
module tb_colormap_lookup_interpolate;
  import clut_pkg::*;

  localparam int ONE         = 1 << FRAC_BITS;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 130;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 300;

  typedef enum logic [1:0] {STEP_WRITE, STEP_MAP, STEP_CFG} step_kind_t;

  // One row of the directed table: a palette write, a map item or a register write.
  typedef struct {
    step_kind_t       kind;
    int               arg;
    logic [RGB_W-1:0] rgb;
    int               sample_v;
    bit               known;
    logic [RGB_W-1:0] want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  clut_in_if  in_ch ();
  clut_out_if out_ch ();

  colormap_lookup_interpolate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the palette and registers, plus the colors still owed by the block.
  logic [RGB_W-1:0] palette_model [MAX_COLORS];
  logic             mode_model  = MODE_LINEAR;
  logic [CNT_W-1:0] count_model = COUNT_RESET;
  logic [RGB_W-1:0] pending_colors [$];
  step_t            directed_steps [$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  bit               hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Out-of-range counts behave as the nearest legal count.
  function automatic int entries_in_use();
    int n;
    n = count_model;
    if (n < 2) n = 2;
    if (n > MAX_COLORS) n = MAX_COLORS;
    return n;
  endfunction

  // Weighted blend of two channel bytes; the low fraction bits are dropped.
  function automatic logic [CH_W-1:0] mix_channel(int a, int b, int f);
    longint acc;
    acc = longint'(a) * (ONE - f) + longint'(b) * f;
    return CH_W'(acc >> FRAC_BITS);
  endfunction

  function automatic logic [RGB_W-1:0] mapped_color(logic signed [SAMPLE_W-1:0] s);
    int n, v, u, scaled, sel, f;
    logic [RGB_W-1:0] a, b;
    n = entries_in_use();
    v = s;
    if (mode_model == MODE_LINEAR) begin
      // Clamp to the unit range, scale by the number of intervals, then blend.
      u = (v < 0) ? 0 : ((v > ONE - 1) ? ONE - 1 : v);
      scaled = u * (n - 1);
      sel = scaled >> FRAC_BITS;
      f = scaled & (ONE - 1);
      if (sel > n - 2) sel = n - 2;
      a = palette_model[sel];
      b = palette_model[sel + 1];
      return {mix_channel(a[23:16], b[23:16], f), mix_channel(a[15:8], b[15:8], f),
              mix_channel(a[7:0], b[7:0], f)};
    end
    // Nearest entry: negative samples pick the first entry, large ones the last.
    if (v < 0) begin
      sel = 0;
    end else begin
      sel = (v * n) >> FRAC_BITS;
      if (sel > n - 1) sel = n - 1;
    end
    return palette_model[sel];
  endfunction

  // Sender gaps: mostly none, some short, a few long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Samples spread over the unit range, with negatives, overflows and entry boundaries.
  function automatic int pick_sample();
    int r, n, k;
    r = $urandom_range(0, 99);
    n = entries_in_use();
    if (r < 62) return $urandom_range(0, ONE - 1);
    if (r < 72) return -int'($urandom_range(1, 131072));
    if (r < 80) return $urandom_range(ONE, 131071);
    if (r < 92) begin
      k = $urandom_range(0, n);
      if (mode_model == MODE_LINEAR) return (k * ONE) / (n - 1) + $urandom_range(0, 2) - 1;
      return (k * ONE) / n + $urandom_range(0, 2) - 1;
    end
    case ($urandom_range(0, 5))
      0: return -131072;
      1: return -1;
      2: return 0;
      3: return ONE - 1;
      4: return ONE;
      default: return 131071;
    endcase
  endfunction

  function automatic void add_step(step_kind_t kind, int arg, logic [RGB_W-1:0] rgb,
                                   int sample_v, bit known, logic [RGB_W-1:0] want);
    step_t st;
    st.kind = kind;
    st.arg = arg;
    st.rgb = rgb;
    st.sample_v = sample_v;
    st.known = known;
    st.want = want;
    directed_steps.push_back(st);
  endfunction

  // Offer one item and record its effect once the block has taken it.
  task automatic send_request(input logic cmd, input int idx, input logic [RGB_W-1:0] rgb,
                              input int sample_v, input bit known,
                              input logic [RGB_W-1:0] want, input bit calm);
    int gap;
    gap = calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.entry_index <= IDX_W'(idx);
    {in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue} <= rgb;
    in_ch.sample_value <= SAMPLE_W'(sample_v);
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      palette_model[idx] = rgb;
    end else begin
      pending_colors.push_back(known ? want : mapped_color(SAMPLE_W'(sample_v)));
    end
  endtask

  // Registers change only once the block has drained, write items included.
  task automatic write_register(input logic [CFG_IDX_W-1:0] reg_idx, input int value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= reg_idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_idx == CFG_MAP_MODE) begin
      mode_model = value[0];
    end else begin
      count_model = CNT_W'(value);
    end
  endtask

  // Result side: random back-pressure, one long hold on request, and the color check.
  initial begin : color_sink
    int stall_left;
    int sink_cycles;
    logic [RGB_W-1:0] want;
    logic [RGB_W-1:0] got;
    stall_left = 0;
    sink_cycles = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.out_red, out_ch.out_green, out_ch.out_blue};
        if (pending_colors.size() == 0) begin
          if (mismatches < 10) $display("%0t: color %h arrived with no map item pending",
                                        $time, got);
          mismatches++;
        end else begin
          want = pending_colors.pop_front();
          if (got[23:16] !== want[23:16] || got[15:8] !== want[15:8] ||
              got[7:0] !== want[7:0]) begin
            if (mismatches < 10) begin
              $display("%0t: red exp %h got %h, green exp %h got %h, blue exp %h got %h",
                       $time, want[23:16], got[23:16], want[15:8], got[15:8],
                       want[7:0], got[7:0]);
            end
            mismatches++;
          end
        end
      end
      // No random stall starts in every fourth window of sink cycles.
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && ((sink_cycles >> 8) % 4) != 0 &&
                   $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      sink_cycles++;
      @(posedge clk);
    end
  end

  // Watchdog: too long without any item moving on either channel.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid & in_ch.ready) === 1'b1 ||
        (out_ch.valid & out_ch.ready) === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    step_t st;
    int cnt;
    logic mode_sel;
    bit calm;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_WRITE;
    in_ch.entry_index <= '0;
    in_ch.entry_red <= '0;
    in_ch.entry_green <= '0;
    in_ch.entry_blue <= '0;
    in_ch.sample_value <= '0;

    // Linear mode with two entries after reset: black to white.
    add_step(STEP_WRITE, 0, 24'h000000, 0, 1'b0, '0);
    add_step(STEP_WRITE, 1, 24'hFFFFFF, 0, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, -131072, 1'b1, 24'h000000);
    add_step(STEP_MAP, 0, 24'h000000, 0, 1'b1, 24'h000000);
    add_step(STEP_MAP, 0, 24'h000000, 131071, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, ONE, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, ONE / 2, 1'b0, '0);
    // A write ignores the sample, a map ignores the entry bytes.
    add_step(STEP_WRITE, 0, 24'h123456, -1, 1'b0, '0);
    add_step(STEP_MAP, 63, 24'hFFFFFF, 0, 1'b1, 24'h123456);
    add_step(STEP_WRITE, 63, 24'hFF00AA, 131071, 1'b0, '0);
    add_step(STEP_WRITE, 1, 24'hABCDEF, 0, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, -1, 1'b1, 24'h123456);
    // Nearest mode: negative, both sides of the midpoint, overflow.
    add_step(STEP_CFG, CFG_MAP_MODE, MODE_NEAREST, 0, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, -131072, 1'b1, 24'h123456);
    add_step(STEP_MAP, 0, 24'h000000, ONE / 2 - 1, 1'b1, 24'h123456);
    add_step(STEP_MAP, 0, 24'h000000, ONE / 2, 1'b1, 24'hABCDEF);
    add_step(STEP_MAP, 0, 24'h000000, 131071, 1'b1, 24'hABCDEF);
    // A count below two acts as two, one above the palette size as the full palette.
    add_step(STEP_CFG, CFG_COLOR_COUNT, 0, 0, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, ONE - 1, 1'b1, 24'hABCDEF);
    add_step(STEP_CFG, CFG_COLOR_COUNT, 127, 0, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, 0, 1'b1, 24'h123456);
    add_step(STEP_MAP, 0, 24'h000000, 131071, 1'b1, 24'hFF00AA);
    add_step(STEP_MAP, 0, 24'h000000, ONE - 1, 1'b1, 24'hFF00AA);
    add_step(STEP_CFG, CFG_MAP_MODE, MODE_LINEAR, 0, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, 0, 1'b1, 24'h123456);
    add_step(STEP_CFG, CFG_COLOR_COUNT, 1, 0, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, ONE - 1, 1'b0, '0);
    add_step(STEP_MAP, 0, 24'h000000, 40000, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[k]) begin
      st = directed_steps[k];
      case (st.kind)
        STEP_CFG: begin
          write_register(CFG_IDX_W'(st.arg), st.rgb);
        end
        STEP_WRITE: begin
          send_request(CMD_WRITE, st.arg, st.rgb, st.sample_v, 1'b0, '0, 1'b0);
        end
        default: begin
          send_request(CMD_MAP, st.arg, st.rgb, st.sample_v, st.known, st.want, 1'b0);
        end
      endcase
    end

    // Load the whole palette so that every later map reads written entries.
    for (int i = 0; i < MAX_COLORS; i++) begin
      send_request(CMD_WRITE, i, RGB_W'($urandom), $urandom_range(0, 262143), 1'b0, '0,
                   1'b0);
    end

    // Random phases, each under its own mode and count.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        mode_sel = (p % 2 == 0) ? MODE_LINEAR : MODE_NEAREST;
      end else begin
        mode_sel = ($urandom_range(0, 1) == 0) ? MODE_LINEAR : MODE_NEAREST;
      end
      case (p)
        0: cnt = 2;
        1: cnt = MAX_COLORS;
        2: cnt = MAX_COLORS;
        3: cnt = 2;
        4: cnt = $urandom_range(MAX_COLORS + 1, 127);
        5: cnt = $urandom_range(0, 1);
        default: cnt = $urandom_range(2, MAX_COLORS);
      endcase
      write_register(CFG_MAP_MODE, mode_sel);
      write_register(CFG_COLOR_COUNT, cnt);
      if (p == 2) hold_req = 1'b1;
      calm = (p % 4 == 1);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          send_request(CMD_WRITE, $urandom_range(0, MAX_COLORS - 1), RGB_W'($urandom),
                       $urandom_range(0, 262143), 1'b0, '0, calm);
        end else begin
          send_request(CMD_MAP, $urandom_range(0, MAX_COLORS - 1), RGB_W'($urandom),
                       pick_sample(), 1'b0, '0, calm);
        end
      end
    end

    // Drain, then allow stray results time to show up.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
